/* hw/rtl/kst_pkg.sv */
// package for the keyed slot table: transaction structs, slot entry layout,
// opcodes and sequencer states
// no dependencies
`default_nettype none

package kst_pkg;

  typedef enum logic [1:0] {
    OP_PUBLISH  = 2'd0,
    OP_WITHDRAW = 2'd1,
    OP_PICK     = 2'd2,
    OP_DISMISS  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e         opcode;
    logic [63:0] owner_hi;
    logic [63:0] owner_lo;
    logic [31:0] now_time;
    logic [15:0] timeout_req;
    logic [31:0] icon_id;
    logic [31:0] launch_value;
    logic        title_empty;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        found;
    logic [2:0]  slot_index;
    logic [63:0] hit_owner_hi;
    logic [63:0] hit_owner_lo;
    logic [31:0] hit_icon;
    logic [31:0] hit_launch;
  } out_item_t;

  // one slot as held in the slot memory
  typedef struct packed {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [31:0] icon;
    logic [31:0] code;
    logic [31:0] published;
    logic [31:0] expiry;
  } entry_t;

  // per-slot decisions from the compare unit
  typedef struct packed {
    logic key_match;
    logic expired;
    logic take_old;
    logic take_best;
  } cmp_flags_t;

  localparam int unsigned TimeoutW = 16;
  localparam logic [TimeoutW-1:0] TimeoutLimitRst = 16'hFFFF;

endpackage

`default_nettype wire

/* hw/rtl/kst_cmp.sv */
// compare unit shared by every scan step of the keyed slot table
// judges one slot against the request and the running search results
// depends on kst_pkg
`default_nettype none

module kst_cmp (
  input  var kst_pkg::entry_t     entry_i,
  input  var kst_pkg::in_item_t   req_i,
  input  logic                    used_i,
  input  logic                    dism_i,
  input  logic                    old_found_i,
  input  logic [31:0]             old_pub_i,
  input  logic                    best_found_i,
  input  logic [31:0]             best_pub_i,
  output kst_pkg::cmp_flags_t     flags_o
);

  logic expired;

  // an expiry of zero means the entry lives forever
  assign expired = (entry_i.expiry != 32'd0) && (req_i.now_time >= entry_i.expiry);

  always_comb begin
    flags_o.key_match = used_i && (entry_i.key_hi == req_i.owner_hi)
                        && (entry_i.key_lo == req_i.owner_lo);
    flags_o.expired   = used_i && expired;
    // strict compares keep the lowest index on ties
    flags_o.take_old  = used_i && (!old_found_i || (entry_i.published < old_pub_i));
    flags_o.take_best = used_i && !expired && !dism_i
                        && (!best_found_i || (entry_i.published > best_pub_i));
  end

endmodule

`default_nettype wire

/* hw/rtl/keyed_slot_table_expiry_evict_oldest.sv */
// top level of the keyed slot table with expiry and oldest-publish eviction
// holds the slot memory, the scan sequencer and the output register
// depends on kst_pkg and kst_cmp
//
// usage: one request transaction on in_valid_i/in_stall_o carries an opcode
// (publish, withdraw, pick, dismiss) and its operands; each request yields
// exactly one result transaction on out_valid_o/out_stall_i.
// a request walks the slot memory one slot per cycle through a single
// compare unit: accept, a prime step for the registered memory read, one
// scan step per slot, a commit step and a done step that loads the result.
// the next request is taken only after the result is loaded. a rejected
// publish skips the prime, scan and commit steps and goes straight from
// accept to the done step.
// in_stall_o is high while a request is in progress. a finished result waits
// in the output register while the next request is accepted; if the receiver
// still stalls when the following result is ready, the sequencer holds it.
// reset empties every slot and sets the timeout limit to its maximum.
// the timeout limit register is written through cfg_we_i/cfg_wdata_i.
`default_nettype none

module keyed_slot_table_expiry_evict_oldest #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  var kst_pkg::in_item_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kst_pkg::out_item_t   out_data_o
);

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  kst_pkg::state_e state_q, state_d;

  logic [kst_pkg::TimeoutW-1:0] limit_q;
  kst_pkg::in_item_t            req_q;
  logic                         rej_q;

  logic [SLOT_COUNT-1:0] used_q;
  logic [SLOT_COUNT-1:0] dism_q;

  kst_pkg::entry_t slot_mem_q [SLOT_COUNT];
  kst_pkg::entry_t rdata_q;
  kst_pkg::entry_t wdata;
  logic [IdxW-1:0] rd_addr;
  logic            mem_we;

  logic [IdxW-1:0] cmp_idx_q;

  logic            match_found_q, free_found_q, old_found_q, best_found_q, removed_q;
  logic [IdxW-1:0] match_idx_q, free_idx_q, old_idx_q, best_idx_q;
  logic [31:0]     old_pub_q, best_pub_q;
  kst_pkg::entry_t best_ent_q;

  logic            accept, reject, scan_step, scan_last, out_load;
  logic [IdxW-1:0] pub_slot;
  logic [kst_pkg::TimeoutW-1:0] tmo;
  kst_pkg::cmp_flags_t flags;
  kst_pkg::out_item_t  res;
  logic                out_valid_q;
  kst_pkg::out_item_t  out_q;

  assign accept    = in_valid_i && !in_stall_o;
  assign reject    = (in_data_i.opcode == kst_pkg::OP_PUBLISH)
                     && (((in_data_i.owner_hi == 64'd0) && (in_data_i.owner_lo == 64'd0))
                         || in_data_i.title_empty);
  assign scan_step = (state_q == kst_pkg::ST_SCAN);
  assign scan_last = scan_step && (cmp_idx_q == LastIdx);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      kst_pkg::ST_IDLE: begin
        if (accept) state_d = reject ? kst_pkg::ST_DONE : kst_pkg::ST_PRIME;
      end
      kst_pkg::ST_PRIME:  state_d = kst_pkg::ST_SCAN;
      kst_pkg::ST_SCAN: begin
        if (cmp_idx_q == LastIdx) state_d = kst_pkg::ST_COMMIT;
      end
      kst_pkg::ST_COMMIT: state_d = kst_pkg::ST_DONE;
      kst_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = kst_pkg::ST_IDLE;
      end
      default: state_d = kst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    rd_addr    = '0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      kst_pkg::ST_IDLE: in_stall_o = 1'b0;
      kst_pkg::ST_PRIME: rd_addr = '0;
      kst_pkg::ST_SCAN: begin
        // fetch the next slot while the current one is judged
        if (cmp_idx_q != LastIdx) rd_addr = cmp_idx_q + IdxW'(1);
      end
      kst_pkg::ST_COMMIT: mem_we = (req_q.opcode == kst_pkg::OP_PUBLISH);
      kst_pkg::ST_DONE:   out_load = !out_valid_q || !out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= kst_pkg::TimeoutLimitRst;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // slot memory
  // ---------------------------------------------------------------------------
  assign tmo = (req_q.timeout_req < limit_q) ? req_q.timeout_req : limit_q;

  always_comb begin
    wdata.key_hi    = req_q.owner_hi;
    wdata.key_lo    = req_q.owner_lo;
    wdata.icon      = req_q.icon_id;
    wdata.code      = req_q.launch_value;
    wdata.published = req_q.now_time;
    wdata.expiry    = (tmo != '0) ? (req_q.now_time + {16'd0, tmo}) : 32'd0;
  end

  // publish target: owner's slot, else first free, else oldest
  assign pub_slot = match_found_q ? match_idx_q :
                    free_found_q  ? free_idx_q  : old_idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) slot_mem_q[pub_slot] <= wdata;
    rdata_q <= slot_mem_q[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // scan
  // ---------------------------------------------------------------------------
  kst_cmp u_cmp (
    .entry_i      (rdata_q),
    .req_i        (req_q),
    .used_i       (used_q[cmp_idx_q]),
    .dism_i       (dism_q[cmp_idx_q]),
    .old_found_i  (old_found_q),
    .old_pub_i    (old_pub_q),
    .best_found_i (best_found_q),
    .best_pub_i   (best_pub_q),
    .flags_o      (flags)
  );

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data_i;
    if (scan_step && flags.take_old) begin
      old_idx_q <= cmp_idx_q;
      old_pub_q <= rdata_q.published;
    end
    if (scan_step && flags.take_best) begin
      best_idx_q <= cmp_idx_q;
      best_pub_q <= rdata_q.published;
      best_ent_q <= rdata_q;
    end
    if (scan_step && flags.key_match && !match_found_q) match_idx_q <= cmp_idx_q;
    if (scan_step && !used_q[cmp_idx_q] && !free_found_q) free_idx_q <= cmp_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rej_q         <= 1'b0;
      cmp_idx_q     <= '0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      old_found_q   <= 1'b0;
      best_found_q  <= 1'b0;
      removed_q     <= 1'b0;
    end else begin
      if (accept) begin
        rej_q         <= reject;
        cmp_idx_q     <= '0;
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
        old_found_q   <= 1'b0;
        best_found_q  <= 1'b0;
        removed_q     <= 1'b0;
      end
      if (scan_step) begin
        if (!scan_last) cmp_idx_q <= cmp_idx_q + IdxW'(1);
        if (flags.key_match) begin
          match_found_q <= 1'b1;
          removed_q     <= 1'b1;
        end
        if (!used_q[cmp_idx_q]) free_found_q <= 1'b1;
        if (flags.take_old)     old_found_q  <= 1'b1;
        if (flags.take_best)    best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      dism_q <= '0;
    end else begin
      if (scan_step) begin
        case (req_q.opcode)
          kst_pkg::OP_WITHDRAW: begin
            if (flags.key_match) used_q[cmp_idx_q] <= 1'b0;
          end
          kst_pkg::OP_PICK, kst_pkg::OP_DISMISS: begin
            if (flags.expired) used_q[cmp_idx_q] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (mem_we) begin
        used_q[pub_slot] <= 1'b1;
        dism_q[pub_slot] <= 1'b0;
      end
      if ((state_q == kst_pkg::ST_COMMIT) && (req_q.opcode == kst_pkg::OP_DISMISS)
          && best_found_q) begin
        dism_q[best_idx_q] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result
  // ---------------------------------------------------------------------------
  always_comb begin
    res = '0;
    case (req_q.opcode)
      kst_pkg::OP_PUBLISH: begin
        res.status = rej_q;
        if (!rej_q) res.slot_index = 3'(pub_slot);
      end
      kst_pkg::OP_WITHDRAW: res.status = !removed_q;
      kst_pkg::OP_PICK, kst_pkg::OP_DISMISS: begin
        if (best_found_q) begin
          res.found        = 1'b1;
          res.slot_index   = 3'(best_idx_q);
          res.hit_owner_hi = best_ent_q.key_hi;
          res.hit_owner_lo = best_ent_q.key_lo;
          res.hit_icon     = best_ent_q.icon;
          res.hit_launch   = best_ent_q.code;
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
